// File: rtl/ppcd_pkg.sv
`default_nettype none

package ppcd_pkg;

	localparam int TIME_W     = 24;
	localparam int DELAY_W    = 21;
	localparam int PCT_W      = 7;
	localparam int COUNT_W    = 7;
	localparam int CFG_DATA_W = 7;
	localparam int SYNC_PROD_W = 48;
	localparam int MPROD_W    = 28;
	localparam int MARGIN_PROD_W = 57;

	// floor(t / 10) for a 24-bit t is (t * ceil(2^27 / 10)) >> 27.
	localparam logic [TIME_W-1:0] SYNC_RECIP = 24'd13421773;
	localparam int SYNC_SHIFT = 27;

	// floor(x / 100) for x below 2^30 is (x * ceil(2^35 / 100)) >> 35.
	localparam logic [28:0] PCT_RECIP = 29'd343597384;
	localparam int PCT_SHIFT = 35;

	localparam logic [PCT_W-1:0]   PCT_MAX          = 7'd100;
	localparam logic [COUNT_W-1:0] PAIR_MAX         = 7'd127;
	localparam logic [PCT_W-1:0]   RESET_TOLERANCE  = 7'd60;
	localparam logic [COUNT_W-1:0] RESET_MIN_PAIRS  = 7'd15;

	typedef enum logic [0:0] {
		CFG_TOLERANCE = 1'b0,
		CFG_MIN_PAIRS = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [TIME_W-1:0] pulse_time;
		logic              frame_end;
	} pulse_req_t;

	typedef struct packed {
		logic       frame_valid;
		logic [7:0] unit_address;
		logic [7:0] network_id;
		logic       switch_state;
	} frame_rsp_t;

endpackage

`default_nettype wire

// File: rtl/rf_pulse_pair_code_decoder.sv
`default_nettype none

// Channel  | Direction | Handshake                   | Carries
// ---------+-----------+-----------------------------+---------------------------------
// in       | input     | in_valid / in_ready         | one pulse duration and frame end
// out      | output    | out_valid / out_ready       | one decoded frame per frame end
// cfg      | input     | cfg_valid / cfg_ready       | register index and write data
//
// One request is accepted every cycle while no stalled frame end holds the pipeline; the request
// that ends a frame moves through the input, product and result registers in turn.
// The pair decision in the second stage needs the tolerance margin, which the sync
// request yields through two chained multipliers; pairs always trail the sync by at
// least two requests, so the margin is ready in time.
// Reset clears the pipeline, the frame state and restores the two registers.
// A stalled result only holds the second stage when that stage also carries a frame end.
module rf_pulse_pair_code_decoder #(
	parameter int CODE_WIDTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  ppcd_pkg::pulse_req_t                 in_data,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output ppcd_pkg::frame_rsp_t                 out_data,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  ppcd_pkg::cfg_index_t                 cfg_index,
	input  logic [ppcd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import ppcd_pkg::*;

	// Configuration registers.
	logic [PCT_W-1:0]   tol_q;
	logic [COUNT_W-1:0] min_pairs_q;

	// Pipeline: input register and product register.
	logic                     valid_s1;
	pulse_req_t               req_s1;
	logic                     valid_s2;
	pulse_req_t               req_s2;
	logic [DELAY_W-1:0]       base_s2;

	// Frame state.
	logic                     in_frame_q;
	logic                     second_half_q;
	logic [TIME_W-1:0]        held_q;
	logic [CODE_WIDTH-1:0]    code_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     failed_q;
	logic [DELAY_W-1:0]       base_q;
	logic [MPROD_W-1:0]       mprod_q;
	logic [DELAY_W-1:0]       margin_q;

	// Result register.
	logic                     out_valid_q;
	frame_rsp_t               rsp_q;

	// Handshake and datapath nets.
	logic                     out_free;
	logic                     s2_go;
	logic                     s2_load;
	logic                     s1_move;
	logic [SYNC_PROD_W-1:0]   sync_prod;
	logic [MARGIN_PROD_W-1:0] margin_prod;
	logic [PCT_W-1:0]         pct_clamp;
	logic [TIME_W-1:0]        d1;
	logic [TIME_W-1:0]        d2;
	logic [TIME_W-1:0]        mg;
	logic                     held_short;
	logic                     held_long;
	logic                     cur_short;
	logic                     cur_long;

	logic                     in_frame_d;
	logic                     second_half_d;
	logic [TIME_W-1:0]        held_d;
	logic [CODE_WIDTH-1:0]    code_d;
	logic [COUNT_W-1:0]       count_d;
	logic                     failed_d;
	logic                     frame_ok;
	frame_rsp_t               rsp_d;

	// The pipeline moves whenever the stage ahead is empty or moving. Only a request
	// that ends a frame needs room in the result register.
	always_comb begin
		out_free = !out_valid_q || out_ready;
		s2_go    = valid_s2 && (!req_s2.frame_end || out_free);
		s2_load  = !valid_s2 || s2_go;
		s1_move  = valid_s1 && s2_load;
		in_ready = !valid_s1 || s1_move;
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= RESET_TOLERANCE;
			min_pairs_q <= RESET_MIN_PAIRS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TOLERANCE: tol_q       <= cfg_data;
				CFG_MIN_PAIRS: min_pairs_q <= cfg_data;
			endcase
		end
	end

	// Sync pulse divided by ten, by reciprocal multiplication.
	assign sync_prod = SYNC_PROD_W'(req_s1.pulse_time) * SYNC_PROD_W'(SYNC_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
		if (s1_move) begin
			req_s2  <= req_s1;
			base_s2 <= sync_prod[SYNC_SHIFT +: DELAY_W];
		end
	end

	// The margin is floor(base * percent / 100). The product is taken when the sync
	// request is consumed, and the division by 100 is registered in the following cycle.
	assign pct_clamp   = (tol_q > PCT_MAX) ? PCT_MAX : tol_q;
	assign margin_prod = MARGIN_PROD_W'(mprod_q) * MARGIN_PROD_W'(PCT_RECIP);

	// Windows are open intervals around one and two base delays. Since the margin
	// never exceeds the base delay, the lower bounds never wrap.
	always_comb begin
		d1 = TIME_W'(base_q);
		d2 = TIME_W'({base_q, 1'b0});
		mg = TIME_W'(margin_q);
		held_short = (held_q > d1 - mg) && (held_q < d1 + mg);
		held_long  = (held_q > d2 - mg) && (held_q < d2 + mg);
		cur_short  = (req_s2.pulse_time > d1 - mg) && (req_s2.pulse_time < d1 + mg);
		cur_long   = (req_s2.pulse_time > d2 - mg) && (req_s2.pulse_time < d2 + mg);
	end

	always_comb begin
		in_frame_d    = in_frame_q;
		second_half_d = second_half_q;
		held_d        = held_q;
		code_d        = code_q;
		count_d       = count_q;
		failed_d      = failed_q;

		if (!in_frame_q) begin
			// Sync pulse opens the frame.
			in_frame_d    = 1'b1;
			second_half_d = 1'b0;
			held_d        = '0;
			code_d        = '0;
			count_d       = '0;
			failed_d      = 1'b0;
		end else if (!second_half_q) begin
			held_d        = req_s2.pulse_time;
			second_half_d = 1'b1;
		end else begin
			second_half_d = 1'b0;
			if (count_q < PAIR_MAX) begin
				count_d = count_q + COUNT_W'(1);
			end
			// Once a pair fails the code stays cleared for the rest of the frame.
			if (!failed_q) begin
				if (held_short && cur_long) begin
					code_d = {code_q[CODE_WIDTH-2:0], 1'b0};
				end else if (held_long && cur_short) begin
					code_d = {code_q[CODE_WIDTH-2:0], 1'b1};
				end else begin
					failed_d = 1'b1;
					code_d   = '0;
				end
			end
		end

		frame_ok = !failed_d && (count_d >= min_pairs_q) && (code_d != '0);
		rsp_d.frame_valid  = frame_ok;
		rsp_d.unit_address = frame_ok ? code_d[15:8]  : 8'd0;
		rsp_d.network_id   = frame_ok ? code_d[23:16] : 8'd0;
		rsp_d.switch_state = frame_ok ? code_d[0]     : 1'b0;

		// A frame end returns to waiting for sync; a lone trailing duration is dropped.
		if (req_s2.frame_end) begin
			in_frame_d    = 1'b0;
			second_half_d = 1'b0;
			held_d        = '0;
			code_d        = '0;
			count_d       = '0;
			failed_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			second_half_q <= 1'b0;
			held_q        <= '0;
			code_q        <= '0;
			count_q       <= '0;
			failed_q      <= 1'b0;
			base_q        <= '0;
			mprod_q       <= '0;
			margin_q      <= '0;
		end else begin
			margin_q <= margin_prod[PCT_SHIFT +: DELAY_W];
			if (s2_go) begin
				in_frame_q    <= in_frame_d;
				second_half_q <= second_half_d;
				held_q        <= held_d;
				code_q        <= code_d;
				count_q       <= count_d;
				failed_q      <= failed_d;
				if (!in_frame_q) begin
					base_q  <= base_s2;
					mprod_q <= MPROD_W'(base_s2) * MPROD_W'(pct_clamp);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_go && req_s2.frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && req_s2.frame_end) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

`default_nettype wire
